/* rtl/core/quoted_token_splitter_assert.svh */
// Assertion helpers shared by the token splitter modules.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef QUOTED_TOKEN_SPLITTER_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define QTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quoted_token_splitter: same-cycle check failed");

// Next-cycle implication.
`define QTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quoted_token_splitter: next-cycle check failed");

`endif

/* rtl/core/qts_pkg.sv */
// ----------------------------------------------------------------------------
// qts_pkg
// Types and constants for the quoted token splitter.
// ----------------------------------------------------------------------------
package qts_pkg;

  // Characters with special meaning
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;

  // Results one byte can cause, and the output queue depth
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_QUOTED  = 3'd3,
    MODE_BARE    = 3'd4
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic       end_mark;
  } out_item_t;

  // Results of one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]                  num;
    out_item_t [MAX_RESULTS-1:0] item;
  } scan_res_t;

endpackage

/* rtl/core/qts_scan.sv */
// ----------------------------------------------------------------------------
// qts_scan
// Tokenizer mode register and per-byte result generation.
// ----------------------------------------------------------------------------
module qts_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  qts_pkg::in_item_t   in_data,
  output qts_pkg::scan_res_t  res
);

  qts_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic                quote_is_single, quote_is_single_next;

  // Byte classification
  logic       is_sep;
  logic [7:0] b;
  logic [7:0] close_quote;

  assign b           = in_data.data_byte;
  assign is_sep      = (b <= qts_pkg::CH_SPACE);
  assign close_quote = quote_is_single ? qts_pkg::CH_SQUOTE : qts_pkg::CH_DQUOTE;

  // Results and next mode for the byte at the input
  always_comb begin
    logic [1:0] n;
    n                    = 2'd0;
    res                  = '0;
    scan_mode_next       = scan_mode;
    quote_is_single_next = quote_is_single;
    unique case (scan_mode)
      qts_pkg::MODE_SLASH: begin
        if (b == qts_pkg::CH_SLASH) begin
          scan_mode_next = qts_pkg::MODE_COMMENT;
        end else begin
          // pending slash opens a bare token, which the byte extends or, if a separator, closes
          res.item[n] = '{token_char: qts_pkg::CH_SLASH, end_mark: 1'b0};
          n = n + 2'd1;
          if (is_sep) begin
            res.item[n] = '{token_char: 8'h00, end_mark: 1'b1};
            scan_mode_next = qts_pkg::MODE_IDLE;
          end else begin
            res.item[n] = '{token_char: b, end_mark: 1'b0};
            scan_mode_next = qts_pkg::MODE_BARE;
          end
          n = n + 2'd1;
        end
      end
      qts_pkg::MODE_COMMENT: begin
        if (b == qts_pkg::CH_NEWLINE) begin
          scan_mode_next = qts_pkg::MODE_IDLE;
        end
      end
      qts_pkg::MODE_QUOTED: begin
        if (b == close_quote || b == 8'h00) begin
          res.item[n] = '{token_char: 8'h00, end_mark: 1'b1};
          scan_mode_next = qts_pkg::MODE_IDLE;
        end else begin
          res.item[n] = '{token_char: b, end_mark: 1'b0};
        end
        n = n + 2'd1;
      end
      qts_pkg::MODE_BARE: begin
        if (is_sep) begin
          res.item[n] = '{token_char: 8'h00, end_mark: 1'b1};
          scan_mode_next = qts_pkg::MODE_IDLE;
        end else begin
          res.item[n] = '{token_char: b, end_mark: 1'b0};
        end
        n = n + 2'd1;
      end
      default: begin
        // between tokens
        if (is_sep) begin
          scan_mode_next = qts_pkg::MODE_IDLE;
        end else if (b == qts_pkg::CH_SLASH) begin
          scan_mode_next = qts_pkg::MODE_SLASH;
        end else if (b == qts_pkg::CH_DQUOTE || b == qts_pkg::CH_SQUOTE) begin
          quote_is_single_next = (b == qts_pkg::CH_SQUOTE);
          scan_mode_next = qts_pkg::MODE_QUOTED;
        end else begin
          res.item[n] = '{token_char: b, end_mark: 1'b0};
          n = n + 2'd1;
          scan_mode_next = qts_pkg::MODE_BARE;
        end
      end
    endcase

    // Last byte closes whatever is still open
    if (in_data.last_byte) begin
      unique case (scan_mode_next)
        qts_pkg::MODE_SLASH: begin
          res.item[n] = '{token_char: qts_pkg::CH_SLASH, end_mark: 1'b0};
          n = n + 2'd1;
          res.item[n] = '{token_char: 8'h00, end_mark: 1'b1};
          n = n + 2'd1;
        end
        qts_pkg::MODE_QUOTED, qts_pkg::MODE_BARE: begin
          res.item[n] = '{token_char: 8'h00, end_mark: 1'b1};
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      scan_mode_next = qts_pkg::MODE_IDLE;
    end
    res.num = n;
  end

  // Mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= qts_pkg::MODE_IDLE;
      quote_is_single <= 1'b0;
    end else if (accept) begin
      scan_mode       <= scan_mode_next;
      quote_is_single <= quote_is_single_next;
    end
  end

`include "quoted_token_splitter_assert.svh"

  `QTS_ASSERT_NEXT(a_last_goes_idle, accept && in_data.last_byte, scan_mode == qts_pkg::MODE_IDLE)
  `QTS_ASSERT_NOW(a_comment_silent, accept && scan_mode == qts_pkg::MODE_COMMENT, res.num == 2'd0)
  `QTS_ASSERT_NOW(a_idle_one_result, scan_mode == qts_pkg::MODE_IDLE && !in_data.last_byte, res.num <= 2'd1)

endmodule

/* rtl/core/qts_outq.sv */
// ----------------------------------------------------------------------------
// qts_outq
// Four-entry shift queue that takes up to three results per transfer in and
// hands one result per transfer out.
// ----------------------------------------------------------------------------
module qts_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qts_pkg::scan_res_t  res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output qts_pkg::out_item_t  out_data
);

  localparam int CntW = $clog2(qts_pkg::QUEUE_DEPTH + 1);
  localparam int IdxW = $clog2(qts_pkg::QUEUE_DEPTH);

  qts_pkg::out_item_t [qts_pkg::QUEUE_DEPTH-1:0] slot, slot_next;
  logic [CntW-1:0] count, count_next;
  logic            pop;
  logic [IdxW-1:0] base;

  // Space for a worst-case byte before any pop this cycle
  assign room      = (count <= CntW'(qts_pkg::QUEUE_DEPTH - qts_pkg::MAX_RESULTS));
  assign out_valid = (count != '0);
  assign out_data  = slot[0];
  assign pop       = out_valid && !out_stall;
  assign base      = count[IdxW-1:0] - IdxW'(pop);

  // Shift out the head, then append new results behind the survivors
  always_comb begin
    for (int i = 0; i < qts_pkg::QUEUE_DEPTH; i++) begin
      if (pop && i < qts_pkg::QUEUE_DEPTH - 1) begin
        slot_next[i] = slot[i+1];
      end else begin
        slot_next[i] = slot[i];
      end
    end
    count_next = count - CntW'(pop);
    if (push) begin
      for (int k = 0; k < qts_pkg::MAX_RESULTS; k++) begin
        if (k < int'(res.num)) begin
          slot_next[base + IdxW'(k)] = res.item[k];
        end
      end
      count_next = count_next + CntW'(res.num);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

`include "quoted_token_splitter_assert.svh"

  `QTS_ASSERT_NOW(a_no_overflow, push, int'(count) + int'(res.num) <= qts_pkg::QUEUE_DEPTH)
  `QTS_ASSERT_NEXT(a_empty_stays, count == '0 && !push, count == '0)
  `QTS_ASSERT_NEXT(a_pop_drops_one, pop && !(push && res.num != 2'd0), count == $past(count) - 1'b1)

endmodule

/* rtl/core/quoted_token_splitter.sv */
// ----------------------------------------------------------------------------
// quoted_token_splitter
// Byte-stream tokenizer: whitespace-separated, quoted and comment-aware.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever at most one result waits in the
// output queue; its results (zero to three: token characters and end
// markers) are registered into the queue and leave it one per transfer.
// A byte inside a token yields one result, so plain text streams at one
// byte per cycle while the output does not stall; a byte that yields two or
// three results (a lone slash that turns into a bare token, or the last byte
// closing a token) holds the input while the four-entry output queue drains.
module quoted_token_splitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qts_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qts_pkg::out_item_t  out_data
);

  logic               accept;
  logic               room;
  qts_pkg::scan_res_t res;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  // Mode tracking and result generation
  qts_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .res     (res)
  );

  // Result queue toward the output
  qts_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* sim/token_splitter_checker.sv */
// ----------------------------------------------------------------------------
// token_splitter_checker
// Watches both channels of the token splitter, predicts the token stream
// from every accepted byte and compares each result transfer in order.
// ----------------------------------------------------------------------------
module token_splitter_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  qts_pkg::in_item_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  qts_pkg::out_item_t          out_data,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // NUL ends a quoted token; end markers carry it as their character
  localparam logic [7:0] NUL_CHAR = 8'h00;

  qts_pkg::scan_mode_t mode;
  logic                quote_single;
  qts_pkg::out_item_t  token_q[$];

  function automatic void push_token(logic [7:0] ch, logic mark);
    qts_pkg::out_item_t r;
    r.token_char = ch;
    r.end_mark   = mark;
    token_q.push_back(r);
  endfunction

  // Byte inside a bare token: a separator closes it
  function automatic void bare_char(logic [7:0] b);
    if (b <= qts_pkg::CH_SPACE) begin
      push_token(NUL_CHAR, 1'b1);
      mode = qts_pkg::MODE_IDLE;
    end else begin
      push_token(b, 1'b0);
      mode = qts_pkg::MODE_BARE;
    end
  endfunction

  // Next-state and token output for one accepted byte
  function automatic void scan_byte(qts_pkg::in_item_t it);
    logic [7:0] b;
    logic [7:0] close_char;
    b = it.data_byte;
    case (mode)
      qts_pkg::MODE_SLASH: begin
        if (b == qts_pkg::CH_SLASH) begin
          mode = qts_pkg::MODE_COMMENT;
        end else begin
          push_token(qts_pkg::CH_SLASH, 1'b0);
          bare_char(b);
        end
      end
      qts_pkg::MODE_COMMENT: begin
        if (b == qts_pkg::CH_NEWLINE) mode = qts_pkg::MODE_IDLE;
      end
      qts_pkg::MODE_QUOTED: begin
        close_char = quote_single ? qts_pkg::CH_SQUOTE : qts_pkg::CH_DQUOTE;
        if (b == close_char || b == NUL_CHAR) begin
          push_token(NUL_CHAR, 1'b1);
          mode = qts_pkg::MODE_IDLE;
        end else begin
          push_token(b, 1'b0);
        end
      end
      qts_pkg::MODE_BARE: begin
        bare_char(b);
      end
      default: begin
        if (b <= qts_pkg::CH_SPACE) begin
          mode = qts_pkg::MODE_IDLE;
        end else if (b == qts_pkg::CH_SLASH) begin
          mode = qts_pkg::MODE_SLASH;
        end else if (b == qts_pkg::CH_DQUOTE || b == qts_pkg::CH_SQUOTE) begin
          quote_single = (b == qts_pkg::CH_SQUOTE);
          mode = qts_pkg::MODE_QUOTED;
        end else begin
          push_token(b, 1'b0);
          mode = qts_pkg::MODE_BARE;
        end
      end
    endcase
    // last byte flushes any open token; an open comment just disappears
    if (it.last_byte) begin
      case (mode)
        qts_pkg::MODE_SLASH: begin
          push_token(qts_pkg::CH_SLASH, 1'b0);
          push_token(NUL_CHAR, 1'b1);
        end
        qts_pkg::MODE_QUOTED, qts_pkg::MODE_BARE: begin
          push_token(NUL_CHAR, 1'b1);
        end
        default: ;
      endcase
      mode = qts_pkg::MODE_IDLE;
    end
  endfunction

  // Results are compared before the same edge's byte is predicted
  always @(posedge clk) begin
    qts_pkg::out_item_t want;
    if (rst) begin
      mode = qts_pkg::MODE_IDLE;
      quote_single = 1'b0;
      token_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual char=%02h end_mark=%0b",
                   $time, out_data.token_char, out_data.end_mark);
        end else begin
          want = token_q.pop_front();
          if (out_data.token_char !== want.token_char) begin
            errors++;
            $display("%0t: token_char mismatch, expected %02h, actual %02h",
                     $time, want.token_char, out_data.token_char);
          end
          if (out_data.end_mark !== want.end_mark) begin
            errors++;
            $display("%0t: end_mark mismatch, expected %0b, actual %0b",
                     $time, want.end_mark, out_data.end_mark);
          end
        end
      end
      if (in_valid && !in_stall) scan_byte(in_data);
    end
    pending = token_q.size();
  end

endmodule

/* sim/quoted_token_splitter_test.sv */
// ----------------------------------------------------------------------------
// quoted_token_splitter_test
// Drives directed and random text into the token splitter with random gaps
// and back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module quoted_token_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int BYTE_TARGET = 206;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  qts_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  qts_pkg::out_item_t out_data;
  int                 errors;
  int                 pending;
  int                 phase = 1;
  int                 sent = 0;
  int                 quiet_cycles = 0;

  quoted_token_splitter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  token_splitter_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver back-pressure: heavy, then light, then none
  always @(negedge clk) begin
    case (phase)
      1:       out_stall <= ($urandom_range(99) < 76);
      2:       out_stall <= ($urandom_range(99) < 29);
      default: out_stall <= 1'b0;
    endcase
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the input off until every predicted token byte has come out.
  // Called at a falling edge, returns at one.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // One byte transfer; starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic l);
    if (sent == 70 || sent == 140) begin
      wait_results();
      phase = phase + 1;
    end
    while ($urandom_range(99) < (phase == 1 ? 29 : phase == 2 ? 76 : 0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: l};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic pick_last();
    return ($urandom_range(99) < 3);
  endfunction

  // Any byte that is not a separator
  function automatic logic [7:0] word_char();
    return 8'($urandom_range(255, 33));
  endfunction

  initial begin
    logic [7:0] b;
    logic [7:0] close_char;
    int         len;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed text
    send_byte(8'h00, 1'b0);                 // NUL while idle is a separator
    send_byte("A", 1'b0);
    send_byte(8'hFF, 1'b0);                 // high byte is a token char
    send_byte(qts_pkg::CH_SPACE, 1'b0);
    send_byte(qts_pkg::CH_DQUOTE, 1'b0);
    send_byte(qts_pkg::CH_SQUOTE, 1'b0);    // other quote inside a quoted token
    send_byte(8'h00, 1'b0);                 // NUL closes a quoted token
    send_byte(qts_pkg::CH_SQUOTE, 1'b0);
    send_byte(qts_pkg::CH_SQUOTE, 1'b0);    // empty token
    send_byte("x", 1'b0);                   // token right after a closing quote
    send_byte(qts_pkg::CH_DQUOTE, 1'b0);    // quote inside a bare token
    send_byte(qts_pkg::CH_NEWLINE, 1'b0);
    send_byte(qts_pkg::CH_SLASH, 1'b0);
    send_byte(qts_pkg::CH_SLASH, 1'b0);
    send_byte("z", 1'b0);
    send_byte(qts_pkg::CH_NEWLINE, 1'b0);
    send_byte(qts_pkg::CH_SLASH, 1'b0);     // second comment line in a row
    send_byte(qts_pkg::CH_SLASH, 1'b0);
    send_byte(qts_pkg::CH_NEWLINE, 1'b0);
    send_byte(qts_pkg::CH_SLASH, 1'b0);
    send_byte("q", 1'b1);                   // slash, char and marker from one byte
    send_byte(qts_pkg::CH_SLASH, 1'b1);     // lone slash as last byte
    send_byte(qts_pkg::CH_SLASH, 1'b0);
    send_byte(qts_pkg::CH_SPACE, 1'b0);     // slash then separator
    send_byte(qts_pkg::CH_DQUOTE, 1'b1);    // quote as last byte

    // Random text, mostly well-formed tokens
    while (sent < BYTE_TARGET) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          do b = word_char();
          while (b == qts_pkg::CH_SLASH || b == qts_pkg::CH_DQUOTE ||
                 b == qts_pkg::CH_SQUOTE);
          send_byte(b, pick_last());
          len = $urandom_range(5);
          repeat (len) send_byte(word_char(), pick_last());
          send_byte(8'($urandom_range(32)), pick_last());
        end
        3, 4: begin
          close_char = $urandom_range(1) ? qts_pkg::CH_SQUOTE : qts_pkg::CH_DQUOTE;
          send_byte(close_char, pick_last());
          len = $urandom_range(5);
          repeat (len) begin
            do b = 8'($urandom_range(255)); while (b == close_char || b == 8'h00);
            send_byte(b, pick_last());
          end
          send_byte(($urandom_range(4) == 0) ? 8'h00 : close_char, pick_last());
        end
        5: begin
          send_byte(qts_pkg::CH_SLASH, pick_last());
          send_byte(qts_pkg::CH_SLASH, pick_last());
          len = $urandom_range(4);
          repeat (len) begin
            do b = 8'($urandom_range(255)); while (b == qts_pkg::CH_NEWLINE);
            send_byte(b, pick_last());
          end
          send_byte(qts_pkg::CH_NEWLINE, pick_last());
        end
        6: begin
          send_byte(qts_pkg::CH_SLASH, pick_last());
          len = $urandom_range(3);
          repeat (len) send_byte(word_char(), pick_last());
          send_byte(8'($urandom_range(32)), pick_last());
        end
        7: begin
          len = $urandom_range(2, 1);
          repeat (len) send_byte(8'($urandom_range(32)), pick_last());
        end
        default: begin
          len = $urandom_range(3, 1);
          repeat (len) send_byte(8'($urandom_range(255)), pick_last());
        end
      endcase
    end

    // Drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
